[rtl/lz77_window_copy_engine_unit_assert.svh]
// Assertion macros shared by the LZ77 window copy engine.
// Each macro expands to one labelled concurrent assertion that is disabled in reset.
`ifndef LZ77_WINDOW_COPY_ENGINE_UNIT_ASSERT_SVH
`define LZ77_WINDOW_COPY_ENGINE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LZWC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LZWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lzwc_pkg.sv]
// Package for the LZ77 window copy engine: sizes, codes, tables and the
// types passed between controller and datapath. No dependencies.
`default_nettype none

package lzwc_pkg;

    localparam int WIN_AW      = 16;
    localparam int MAX_PIECE   = 64;
    localparam int POS_W       = 30;
    localparam int DIST_W      = 24;
    localparam int REM_W       = 25;
    localparam int LEN_W       = 7;
    localparam int SUM_W       = 26;
    localparam int NUM_SHORT_CODES = 16;

    localparam logic [POS_W-1:0] MAX_BACK = POS_W'((1 << WIN_AW) - 16);

    localparam logic [1:0] OP_LITERAL = 2'd0;
    localparam logic [1:0] OP_COPY    = 2'd1;
    localparam logic [1:0] OP_BEGIN   = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_DIST  = 3'd1;
    localparam logic [2:0] ST_FAR_DIST  = 3'd2;
    localparam logic [2:0] ST_PAST_END  = 3'd3;
    localparam logic [2:0] ST_HALTED    = 3'd4;

    localparam logic [DIST_W-1:0] RECENT_INIT [4] = '{24'd16, 24'd15, 24'd11, 24'd4};

    localparam logic [1:0] SLOT_BACK [NUM_SHORT_CODES] = '{
        2'd3, 2'd2, 2'd1, 2'd0, 2'd3, 2'd3, 2'd3, 2'd3,
        2'd3, 2'd3, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2
    };

    localparam logic signed [2:0] DIST_ADJUST [NUM_SHORT_CODES] = '{
        3'sd0, 3'sd0, 3'sd0, 3'sd0, -3'sd1, 3'sd1, -3'sd2, 3'sd2,
        -3'sd3, 3'sd3, -3'sd1, 3'sd1, -3'sd2, 3'sd2, -3'sd3, 3'sd3
    };

    // Input tdata layout, lowest field in the lowest bits.
    typedef struct packed {
        logic [REM_W-1:0]  blk_len;
        logic [DIST_W-1:0] dist_code;
        logic [LEN_W-1:0]  piece_len;
        logic [7:0]        literal_byte;
    } t_in_data;

    typedef struct packed {
        logic       latch;
        logic       set_rem;
        logic       calc_dist;
        logic       check;
        logic       emit_lit;
        logic       emit_err;
        logic [2:0] err_code;
        logic       prime;
        logic       copy_step;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       halted;
        logic       rem_zero;
        logic       dist_bad;
        logic       dist_over;
        logic       len_over;
        logic       len_zero;
        logic       last_byte;
        logic       out_free;
    } t_dp_status;

endpackage

`default_nettype wire

[rtl/lz77_window_copy_engine_unit.sv]
// Top level of the LZ77 window copy engine: joins controller and datapath.
// Depends on lzwc_pkg, lzwc_ctrl, lzwc_datapath and the assertion macro header.
`default_nettype none
`include "lz77_window_copy_engine_unit_assert.svh"

// This block is the back end of an LZ77 decompressor. Each input item is one
// command chosen by s_axis_tuser: begin a block of a given length, append a
// literal byte, or copy a piece of up to 64 bytes from earlier output, the
// distance coming from a distance code (codes below 16 select one of the
// last four distances with a small offset, larger codes give code minus 15).
// Every byte written to the 64 KiB window also leaves as one output item,
// with tlast on the final item that a command causes. A failed check (zero
// or negative distance, distance beyond the window, bytes past the block
// end) produces a single item with a non-zero status and halts the engine,
// after which all but unused commands get the halted status until reset.
// Sequence: an item is taken in the idle state and decoded in the next
// cycle. A literal then passes through the literal state, which offers
// its output item; a command refused at decode (halted engine, or a
// literal with no room left in the block) goes through the error state.
// A copy has a check state for its distance and length checks; an error
// found there goes through the error state, a zero-length piece returns
// to rest. Otherwise a prime state starts the window memory read and the
// copy state writes one byte per cycle while the output register has
// room; the window memory, with one write and one registered read port,
// sets this rate. A begin or an unused command returns to rest after
// decode. Output stalls hold the sequencer in the literal, error and copy
// states. The next item is taken as soon as the sequencer is back at rest,
// even while the last result still waits in the output register.
// The window needs no clearing pass after reset.
module lz77_window_copy_engine_unit import lzwc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: literal_byte [7:0], piece_len [14:8], dist_code [38:15],
    //        blk_len [63:39]
    input  logic [63:0] s_axis_tdata,
    // tuser: op [1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: data_byte [7:0]
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast,
    // tuser: status [2:0]
    output logic [2:0]  m_axis_tuser
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    t_in_data   in_data;

    // The input bus already carries the fields in the packed order.
    assign in_data = t_in_data'(s_axis_tdata);

    lzwc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    lzwc_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_data    (in_data),
        .i_in_op      (s_axis_tuser),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_byte   (m_axis_tdata),
        .o_out_last   (m_axis_tlast),
        .o_out_status (m_axis_tuser)
    );

    // A new result may only be loaded when the output register is free.
    `LZWC_ASSERT_SAME(a_emit_needs_room, i_clk, i_rst_n,
        dp_cmd.emit_lit || dp_cmd.emit_err || dp_cmd.copy_step,
        dp_status.out_free, "result loaded into an occupied output register")

    // At most one result source drives the output register per cycle.
    `LZWC_ASSERT_SAME(a_single_source, i_clk, i_rst_n, 1'b1,
        $onehot0({dp_cmd.emit_lit, dp_cmd.emit_err, dp_cmd.copy_step, dp_cmd.prime}),
        "several datapath actions issued together")

    // An error result leaves the engine halted.
    `LZWC_ASSERT_NEXT(a_err_halts, i_clk, i_rst_n, dp_cmd.emit_err,
        dp_status.halted, "engine not halted after an error result")

    // Error items always close the command.
    `LZWC_ASSERT_SAME(a_err_is_last, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tuser != ST_OK),
        m_axis_tlast && (m_axis_tdata == 8'd0), "error item without tlast or zero data")

endmodule

`default_nettype wire

[rtl/lzwc_ctrl.sv]
// Controller of the LZ77 window copy engine: sequences each command.
// Depends on lzwc_pkg; drives the datapath through t_dp_cmd.
`default_nettype none

module lzwc_ctrl import lzwc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_ERR    = 3'd3;
    localparam logic [2:0] S_LIT    = 3'd4;
    localparam logic [2:0] S_PRIME  = 3'd5;
    localparam logic [2:0] S_COPY   = 3'd6;

    logic [2:0] r_state, n_state;
    logic [2:0] r_err, n_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_err   <= ST_OK;
        end else begin
            r_state <= n_state;
            r_err   <= n_err;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_err   = r_err;
        o_cmd   = '0;
        o_cmd.err_code = r_err;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.op == OP_UNUSED) begin
                    n_state = S_IDLE;
                end else if (i_status.halted) begin
                    n_err   = ST_HALTED;
                    n_state = S_ERR;
                end else begin
                    case (i_status.op)
                        OP_BEGIN: begin
                            o_cmd.set_rem = 1'b1;
                            n_state       = S_IDLE;
                        end
                        OP_LITERAL: begin
                            if (i_status.rem_zero) begin
                                n_err   = ST_PAST_END;
                                n_state = S_ERR;
                            end else begin
                                n_state = S_LIT;
                            end
                        end
                        default: begin
                            o_cmd.calc_dist = 1'b1;
                            n_state         = S_CHECK;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_status.dist_bad) begin
                    n_err   = ST_BAD_DIST;
                    n_state = S_ERR;
                end else if (i_status.dist_over) begin
                    n_err   = ST_FAR_DIST;
                    n_state = S_ERR;
                end else if (i_status.len_over) begin
                    n_err   = ST_PAST_END;
                    n_state = S_ERR;
                end else if (i_status.len_zero) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_PRIME;
                end
            end
            S_ERR: begin
                if (i_status.out_free) begin
                    o_cmd.emit_err = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_LIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_lit = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_PRIME: begin
                o_cmd.prime = 1'b1;
                n_state     = S_COPY;
            end
            S_COPY: begin
                if (i_status.out_free) begin
                    o_cmd.copy_step = 1'b1;
                    if (i_status.last_byte) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/lzwc_datapath.sv]
// Datapath of the LZ77 window copy engine: window memory, distance cache,
// position and length counters and the output register. Depends on lzwc_pkg.
`default_nettype none

module lzwc_datapath import lzwc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_data   i_in_data,
    input  logic [1:0] i_in_op,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic [2:0] o_out_status
);

    logic [7:0]             r_window [1 << WIN_AW];

    logic [1:0]             r_op;
    logic [7:0]             r_lit;
    logic [LEN_W-1:0]       r_len;
    logic [DIST_W-1:0]      r_code;
    logic [REM_W-1:0]       r_blen;

    logic [DIST_W-1:0]      r_cache [4];
    logic [1:0]             r_slot;
    logic [SUM_W-1:0]       r_dist;
    logic [POS_W-1:0]       r_wp;
    logic [REM_W-1:0]       r_rem;
    logic                   r_limit;
    logic                   r_halted;
    logic [WIN_AW-1:0]      r_src;
    logic [LEN_W-1:0]       r_cnt;
    logic [7:0]             r_rd;
    logic [7:0]             r_last_wr;

    logic                   r_out_valid;
    logic [7:0]             r_out_byte;
    logic                   r_out_last;
    logic [2:0]             r_out_status;

    logic [LEN_W-1:0]       sat_len;
    logic [1:0]             cache_idx;
    logic [2:0]             adj;
    logic [SUM_W-1:0]       n_dist;
    logic                   dist_bad;
    logic                   wp_below;
    logic [POS_W-1:0]       max_dist;
    logic                   dist_over;
    logic                   dist_one;
    logic [7:0]             copy_byte;
    logic                   wr_en;
    logic [7:0]             wr_byte;
    logic                   rd_en;
    logic                   out_free;

    assign sat_len = (i_in_data.piece_len > LEN_W'(MAX_PIECE))
                   ? LEN_W'(MAX_PIECE) : i_in_data.piece_len;

    // Short codes reach back into the cache relative to the current slot.
    assign cache_idx = r_slot + SLOT_BACK[r_code[3:0]];
    assign adj       = DIST_ADJUST[r_code[3:0]];

    always_comb begin
        if (r_code[DIST_W-1:4] == '0) begin
            n_dist = {2'b00, r_cache[cache_idx]} + {{(SUM_W-3){adj[2]}}, adj};
        end else begin
            n_dist = {2'b00, r_code} - SUM_W'(NUM_SHORT_CODES - 1);
        end
    end

    assign dist_bad  = r_dist[SUM_W-1] || (r_dist == '0);
    assign wp_below  = (r_wp < MAX_BACK);
    assign max_dist  = (!r_limit && wp_below) ? r_wp : MAX_BACK;
    assign dist_over = {{(POS_W-SUM_W+1){1'b0}}, r_dist[SUM_W-2:0]} > max_dist;
    assign dist_one  = (r_dist == SUM_W'(1));

    // At distance one every copied byte repeats the byte written just before.
    assign copy_byte = dist_one ? r_last_wr : r_rd;
    assign wr_en     = i_cmd.emit_lit || i_cmd.copy_step;
    assign wr_byte   = i_cmd.emit_lit ? r_lit : copy_byte;
    assign rd_en     = i_cmd.prime || i_cmd.copy_step;
    assign out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_window[r_wp[WIN_AW-1:0]] <= wr_byte;
        end
        if (rd_en) begin
            r_rd <= r_window[r_src];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= i_in_op;
            r_lit  <= i_in_data.literal_byte;
            r_len  <= sat_len;
            r_code <= i_in_data.dist_code;
            r_blen <= i_in_data.blk_len;
        end
        if (i_cmd.calc_dist) begin
            r_dist <= n_dist;
        end
        if (i_cmd.check) begin
            r_src <= r_wp[WIN_AW-1:0] - r_dist[WIN_AW-1:0];
            r_cnt <= r_len;
        end else if (rd_en) begin
            r_src <= r_src + 1'b1;
        end
        if (i_cmd.copy_step) begin
            r_cnt <= r_cnt - 1'b1;
        end
        if (wr_en) begin
            r_last_wr <= wr_byte;
        end
        if (i_cmd.emit_lit || i_cmd.copy_step) begin
            r_out_byte   <= wr_byte;
            r_out_last   <= i_cmd.emit_lit || (r_cnt == LEN_W'(1));
            r_out_status <= ST_OK;
        end else if (i_cmd.emit_err) begin
            r_out_byte   <= 8'd0;
            r_out_last   <= 1'b1;
            r_out_status <= i_cmd.err_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_cache[i] <= RECENT_INIT[i];
            end
            r_slot      <= '0;
            r_wp        <= '0;
            r_rem       <= '0;
            r_limit     <= 1'b0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.check && !dist_bad) begin
                if (r_code != '0) begin
                    r_cache[r_slot] <= r_dist[DIST_W-1:0];
                    r_slot          <= r_slot + 1'b1;
                end
                if (r_limit || !wp_below) begin
                    r_limit <= 1'b1;
                end
            end
            if (i_cmd.set_rem) begin
                r_rem <= r_blen;
            end else if (wr_en) begin
                r_rem <= r_rem - 1'b1;
            end
            if (wr_en) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_cmd.emit_err) begin
                r_halted <= 1'b1;
            end
            if (i_cmd.emit_lit || i_cmd.emit_err || i_cmd.copy_step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.op        = r_op;
        o_status.halted    = r_halted;
        o_status.rem_zero  = (r_rem == '0);
        o_status.dist_bad  = dist_bad;
        o_status.dist_over = dist_over;
        o_status.len_over  = {{(REM_W-LEN_W){1'b0}}, r_len} > r_rem;
        o_status.len_zero  = (r_len == '0);
        o_status.last_byte = (r_cnt == LEN_W'(1));
        o_status.out_free  = out_free;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_out_last   = r_out_last;
    assign o_out_status = r_out_status;

endmodule

`default_nettype wire
